// ===== hdl/tiv_pkg.sv =====
// ----------------------------------------------------------------------------
// tiv_pkg
// Shared sizes and types for the per-vertex top-four influence keeper.
// ----------------------------------------------------------------------------
package tiv_pkg;

  localparam int MAX_VERTICES     = 4096;
  localparam int SLOTS_PER_VERTEX = 4;

  localparam int VTX_W    = 12;
  localparam int WEIGHT_W = 16;
  localparam int BONE_W   = 8;
  localparam int SLOT_OUT_W = 2;

  localparam int VTX_AW = $clog2(MAX_VERTICES);
  localparam int SLOT_W = (SLOTS_PER_VERTEX > 1) ? $clog2(SLOTS_PER_VERTEX) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_VERTEX + 1);

  localparam int ENTRY_W = WEIGHT_W + BONE_W;
  localparam int ROW_W   = SLOTS_PER_VERTEX * ENTRY_W;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [BONE_W-1:0]   bone;
  } entry_t;

  typedef entry_t [SLOTS_PER_VERTEX-1:0] row_t;

endpackage

// ===== hdl/top4_influence_per_vertex.sv =====
// ----------------------------------------------------------------------------
// top4_influence_per_vertex
// Keeps the four strongest (weight, bone) influences of every vertex.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on the rising edge where start is high and busy is
//   low. operation selects add (keep the pair if it ranks in the top four)
//   or read (clear the count of the vertex and emit all of its slots).
//   An add reads the vertex row and, while the vertex has a free slot,
//   writes the pair to it at once; once it is full it goes on to scan
//   for the smallest weight and write back. A read emits one result per
//   slot on consecutive cycles, each marked by strobe for one cycle;
//   last marks the final slot.
//   One request is in flight at a time; busy covers the whole
//   read-modify-write, so the count and row memories never see overlapping
//   accesses to the same vertex.
//   After reset the count memory is swept to zero, one vertex per cycle,
//   across all MAX_VERTICES (4096) vertices with busy high.
//   Results cannot be held off by the receiver; they leave on the strobe.
// ----------------------------------------------------------------------------
module top4_influence_per_vertex (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [tiv_pkg::VTX_W-1:0]     vertex_id,
  input  logic [tiv_pkg::WEIGHT_W-1:0]  weight,
  input  logic [tiv_pkg::BONE_W-1:0]    bone_index,
  output logic                          strobe,
  output logic [tiv_pkg::VTX_W-1:0]     vertex_out,
  output logic [tiv_pkg::SLOT_OUT_W-1:0] slot,
  output logic [tiv_pkg::WEIGHT_W-1:0]  slot_weight,
  output logic [tiv_pkg::BONE_W-1:0]    slot_bone,
  output logic                          last
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT
  } state_t;

  state_t state;

  // Latched request
  logic                         op_q;
  logic [tiv_pkg::VTX_W-1:0]    vtx_q;
  logic [tiv_pkg::WEIGHT_W-1:0] w_q;
  logic [tiv_pkg::BONE_W-1:0]   b_q;
  logic                         ok_q;

  logic [tiv_pkg::VTX_AW-1:0]   clr_addr;
  logic [tiv_pkg::VTX_AW-1:0]   vtx_addr;
  logic [tiv_pkg::VTX_AW-1:0]   req_addr;
  logic                         accept;
  logic                         req_ok;

  tiv_pkg::row_t                row_q;
  logic [tiv_pkg::CNT_W-1:0]    n_q;
  logic [tiv_pkg::SLOT_W-1:0]   j;
  logic [tiv_pkg::SLOT_W-1:0]   min_idx;
  logic [tiv_pkg::WEIGHT_W-1:0] min_w;

  // Memory ports
  logic                         cnt_we;
  logic [tiv_pkg::VTX_AW-1:0]   cnt_waddr;
  logic [tiv_pkg::CNT_W-1:0]    cnt_wdata;
  logic [tiv_pkg::CNT_W-1:0]    cnt_rdata;
  logic                         row_we;
  logic [tiv_pkg::ROW_W-1:0]    row_wdata;
  logic [tiv_pkg::ROW_W-1:0]    row_rdata;

  tiv_pkg::row_t                row_rd;
  tiv_pkg::row_t                row_fill;
  tiv_pkg::row_t                row_repl;
  logic [tiv_pkg::SLOT_W-1:0]   scan_idx;
  logic [tiv_pkg::WEIGHT_W-1:0] scan_w;
  logic                         not_full;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign req_addr = tiv_pkg::VTX_AW'(vertex_id);
  assign req_ok   = (32'(vertex_id) < 32'(tiv_pkg::MAX_VERTICES));
  assign vtx_addr = tiv_pkg::VTX_AW'(vtx_q);
  assign row_rd   = tiv_pkg::row_t'(row_rdata);
  assign not_full = (32'(cnt_rdata) < 32'(tiv_pkg::SLOTS_PER_VERTEX));

  tiv_ram #(
    .WIDTH (tiv_pkg::CNT_W),
    .DEPTH (tiv_pkg::MAX_VERTICES)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_en   (accept),
    .rd_addr (req_addr),
    .rd_data (cnt_rdata)
  );

  tiv_ram #(
    .WIDTH (tiv_pkg::ROW_W),
    .DEPTH (tiv_pkg::MAX_VERTICES)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (vtx_addr),
    .wr_data (row_wdata),
    .rd_en   (accept),
    .rd_addr (req_addr),
    .rd_data (row_rdata)
  );

  // Place the new pair in the next free slot of the row just read
  always_comb begin
    row_fill = row_rd;
    row_fill[tiv_pkg::SLOT_W'(cnt_rdata)] = '{weight: w_q, bone: b_q};
  end

  // Replace the smallest slot found by the scan
  always_comb begin
    row_repl = row_q;
    row_repl[min_idx] = '{weight: w_q, bone: b_q};
  end

  // Smallest weight, lowest slot on ties
  always_comb begin
    scan_idx = '0;
    scan_w   = row_q[0].weight;
    for (int k = 1; k < tiv_pkg::SLOTS_PER_VERTEX; k++) begin
      if (row_q[k].weight < scan_w) begin
        scan_w   = row_q[k].weight;
        scan_idx = tiv_pkg::SLOT_W'(k);
      end
    end
  end

  // Memory write control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = vtx_addr;
    cnt_wdata = '0;
    row_we    = 1'b0;
    row_wdata = row_fill;
    case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
      end
      ST_LOOK: begin
        if (ok_q && op_q == tiv_pkg::OP_READ) begin
          cnt_we = 1'b1;
        end else if (ok_q && not_full) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + tiv_pkg::CNT_W'(1);
          row_we    = 1'b1;
        end
      end
      ST_WRITE: begin
        row_wdata = row_repl;
        row_we    = (w_q > min_w);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      strobe   <= 1'b0;
      last     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + tiv_pkg::VTX_AW'(1);
          if (clr_addr == tiv_pkg::VTX_AW'(tiv_pkg::MAX_VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          row_q <= row_rd;
          n_q   <= ok_q ? cnt_rdata : '0;
          j     <= '0;
          if (op_q == tiv_pkg::OP_READ) begin
            state <= ST_EMIT;
          end else if (ok_q && !not_full) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          min_idx <= scan_idx;
          min_w   <= scan_w;
          state   <= ST_WRITE;
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_EMIT: begin
          strobe     <= 1'b1;
          vertex_out <= vtx_q;
          slot       <= tiv_pkg::SLOT_OUT_W'(j);
          if (32'(j) < 32'(n_q)) begin
            slot_weight <= row_q[j].weight;
            slot_bone   <= row_q[j].bone;
          end else begin
            slot_weight <= '0;
            slot_bone   <= '0;
          end
          j <= j + tiv_pkg::SLOT_W'(1);
          if (32'(j) == tiv_pkg::SLOTS_PER_VERTEX - 1) begin
            last  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the request for the duration of its processing
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= operation;
      vtx_q <= vertex_id;
      w_q  <= weight;
      b_q  <= bone_index;
      ok_q <= req_ok;
    end
  end

endmodule

// ===== hdl/tiv_ram.sv =====
// ----------------------------------------------------------------------------
// tiv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tiv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
